// File: hw/rtl/pmmtw_pkg.sv
// shared types and constants for the pack min/max summary with trim window
`timescale 1ns / 1ps

package pmmtw_pkg;

	// default width of one column value
	localparam int unsigned VALUE_WIDTH_DEF = 64;

	// configuration register index
	localparam int unsigned CFG_INDEX_WIDTH = 1;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_WINDOW_LOW  = 1'b0,
		REG_WINDOW_HIGH = 1'b1
	} cfg_reg_t;

	// slave-side tuser layout
	localparam int unsigned USER_WIDTH      = 2;
	localparam int unsigned USER_IS_DELETED = 0;
	localparam int unsigned USER_IS_NULL    = 1;

	// per-row control flags carried with the value
	typedef struct packed {
		logic last_row;
		logic is_null;
		logic is_deleted;
	} row_flags_t;

	// single-bit fields of one pack summary
	typedef struct packed {
		logic above_seen;
		logic below_seen;
		logic trim_has_value;
		logic null_seen;
		logic plain_has_value;
	} sum_flags_t;

endpackage

// File: hw/rtl/pmmtw_in_stage.sv
// input register stage: captures one row transaction per cycle while s_tready is high
`timescale 1ns / 1ps

module pmmtw_in_stage #(
	parameter int unsigned VALUE_WIDTH = pmmtw_pkg::VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [VALUE_WIDTH-1:0] in_value,
	input  pmmtw_pkg::row_flags_t  in_flags,
	input  logic                   take,
	output logic                   valid_s1,
	output logic [VALUE_WIDTH-1:0] value_s1,
	output pmmtw_pkg::row_flags_t  flags_s1
);

	logic accept;

	// room when empty or when the held row moves on this cycle
	assign s_tready = !valid_s1 || take;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_s1 <= in_value;
			flags_s1 <= in_flags;
		end
	end

endmodule

// File: hw/rtl/pmmtw_accum.sv
// window registers, running min/max state and per-row update
`timescale 1ns / 1ps

module pmmtw_accum #(
	parameter int unsigned VALUE_WIDTH = pmmtw_pkg::VALUE_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [pmmtw_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [VALUE_WIDTH-1:0]                cfg_wdata,
	input  logic                                  row_take,
	input  logic [VALUE_WIDTH-1:0]                row_value,
	input  pmmtw_pkg::row_flags_t                 row_flags,
	output pmmtw_pkg::sum_flags_t                 sum_flags,
	output logic [VALUE_WIDTH-1:0]                sum_plain_min,
	output logic [VALUE_WIDTH-1:0]                sum_plain_max,
	output logic [VALUE_WIDTH-1:0]                sum_trim_min,
	output logic [VALUE_WIDTH-1:0]                sum_trim_max
);

	logic [VALUE_WIDTH-1:0] win_low_q;
	logic [VALUE_WIDTH-1:0] win_high_q;

	logic [VALUE_WIDTH-1:0] plain_min_q;
	logic [VALUE_WIDTH-1:0] plain_max_q;
	logic [VALUE_WIDTH-1:0] trim_min_q;
	logic [VALUE_WIDTH-1:0] trim_max_q;
	pmmtw_pkg::sum_flags_t  flags_q;

	logic use_row;
	logic is_below;
	logic in_win;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_low_q  <= '0;
			win_high_q <= '1;
		end else if (cfg_we) begin
			unique case (pmmtw_pkg::cfg_reg_t'(cfg_index))
				pmmtw_pkg::REG_WINDOW_LOW:  win_low_q  <= cfg_wdata;
				pmmtw_pkg::REG_WINDOW_HIGH: win_high_q <= cfg_wdata;
				default:                    win_low_q  <= win_low_q;
			endcase
		end
	end

	// next state including the current row; also the summary on a last row
	always_comb begin
		use_row  = !row_flags.is_deleted && !row_flags.is_null;
		is_below = row_value < win_low_q;
		in_win   = !is_below && (row_value < win_high_q);

		sum_flags     = flags_q;
		sum_plain_min = plain_min_q;
		sum_plain_max = plain_max_q;
		sum_trim_min  = trim_min_q;
		sum_trim_max  = trim_max_q;

		if (!row_flags.is_deleted && row_flags.is_null) begin
			sum_flags.null_seen = 1'b1;
		end
		if (use_row) begin
			if (!flags_q.plain_has_value || row_value < plain_min_q) begin
				sum_plain_min = row_value;
			end
			if (!flags_q.plain_has_value || row_value > plain_max_q) begin
				sum_plain_max = row_value;
			end
			sum_flags.plain_has_value = 1'b1;
			priority if (in_win) begin
				if (!flags_q.trim_has_value || row_value < trim_min_q) begin
					sum_trim_min = row_value;
				end
				if (!flags_q.trim_has_value || row_value > trim_max_q) begin
					sum_trim_max = row_value;
				end
				sum_flags.trim_has_value = 1'b1;
			end else if (is_below) begin
				sum_flags.below_seen = 1'b1;
			end else begin
				sum_flags.above_seen = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q     <= '0;
			plain_min_q <= '0;
			plain_max_q <= '0;
			trim_min_q  <= '0;
			trim_max_q  <= '0;
		end else if (row_take) begin
			if (row_flags.last_row) begin
				flags_q     <= '0;
				plain_min_q <= '0;
				plain_max_q <= '0;
				trim_min_q  <= '0;
				trim_max_q  <= '0;
			end else begin
				flags_q     <= sum_flags;
				plain_min_q <= sum_plain_min;
				plain_max_q <= sum_plain_max;
				trim_min_q  <= sum_trim_min;
				trim_max_q  <= sum_trim_max;
			end
		end
	end

endmodule

// File: hw/rtl/pmmtw_out_reg.sv
// result register: packs and holds one summary transaction
`timescale 1ns / 1ps

module pmmtw_out_reg #(
	parameter int unsigned VALUE_WIDTH = pmmtw_pkg::VALUE_WIDTH_DEF,
	localparam int unsigned SUM_WIDTH  = 4 * VALUE_WIDTH + 5,
	localparam int unsigned OUT_WIDTH  = ((SUM_WIDTH + 7) / 8) * 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  pmmtw_pkg::sum_flags_t  sum_flags,
	input  logic [VALUE_WIDTH-1:0] sum_plain_min,
	input  logic [VALUE_WIDTH-1:0] sum_plain_max,
	input  logic [VALUE_WIDTH-1:0] sum_trim_min,
	input  logic [VALUE_WIDTH-1:0] sum_trim_max,
	output logic                   free,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_WIDTH-1:0]   m_tdata
);

	logic [OUT_WIDTH-1:0] packed_sum;

	assign free = !m_tvalid || m_tready;

	assign packed_sum = {
		{(OUT_WIDTH - SUM_WIDTH){1'b0}},
		sum_flags.above_seen,
		sum_flags.below_seen,
		sum_trim_max,
		sum_trim_min,
		sum_flags.trim_has_value,
		sum_flags.null_seen,
		sum_plain_max,
		sum_plain_min,
		sum_flags.plain_has_value
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata <= packed_sum;
		end
	end

endmodule

// File: hw/rtl/pack_min_max_with_trim_window_top.sv
// top level of the pack min/max summary with trim window
`timescale 1ns / 1ps

// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  s_tdata value, s_tuser deleted/null, s_tlast last row
// m_*       out  m_tvalid/m_tready  m_tdata one pack summary
// cfg_*     in   cfg_we             cfg_index register, cfg_wdata value
//
// one row transaction per cycle while s_tready is high; a row is held in the input register,
// and its summary (on the last row) is registered in the result register and shown on m_*
// the running min/max compare against registers sets the clock-to-clock path
// arst_n clears run state, the window to [0, all ones) and both valids
// s_tready drops only while a last row waits for a stalled summary

module pack_min_max_with_trim_window_top #(
	parameter int unsigned VALUE_WIDTH = pmmtw_pkg::VALUE_WIDTH_DEF,
	localparam int unsigned IN_WIDTH   = ((VALUE_WIDTH + 7) / 8) * 8,
	localparam int unsigned OUT_WIDTH  = ((4 * VALUE_WIDTH + 5 + 7) / 8) * 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// slave side: one row per transaction
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [IN_WIDTH-1:0]                   s_tdata,  // value
	input  logic [pmmtw_pkg::USER_WIDTH-1:0]      s_tuser,  // is_deleted, is_null
	input  logic                                  s_tlast,  // last_row
	// master side: one summary per pack
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// plain_has_value, plain_min, plain_max, null_seen, trim_has_value,
	// trim_min, trim_max, below_seen, above_seen
	output logic [OUT_WIDTH-1:0]                  m_tdata,
	// configuration writes
	input  logic                                  cfg_we,
	input  logic [pmmtw_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [VALUE_WIDTH-1:0]                cfg_wdata
);

	pmmtw_pkg::row_flags_t  in_flags;
	pmmtw_pkg::row_flags_t  flags_s1;
	logic                   valid_s1;
	logic [VALUE_WIDTH-1:0] value_s1;

	logic                   take;
	logic                   out_free;
	logic                   sum_load;

	pmmtw_pkg::sum_flags_t  sum_flags;
	logic [VALUE_WIDTH-1:0] sum_plain_min;
	logic [VALUE_WIDTH-1:0] sum_plain_max;
	logic [VALUE_WIDTH-1:0] sum_trim_min;
	logic [VALUE_WIDTH-1:0] sum_trim_max;

	assign in_flags.is_deleted = s_tuser[pmmtw_pkg::USER_IS_DELETED];
	assign in_flags.is_null    = s_tuser[pmmtw_pkg::USER_IS_NULL];
	assign in_flags.last_row   = s_tlast;

	// an ordinary row always moves on; a last row needs the result register
	assign take     = valid_s1 && (!flags_s1.last_row || out_free);
	assign sum_load = take && flags_s1.last_row;

	pmmtw_in_stage #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.in_value (s_tdata[VALUE_WIDTH-1:0]),
		.in_flags (in_flags),
		.take     (take),
		.valid_s1 (valid_s1),
		.value_s1 (value_s1),
		.flags_s1 (flags_s1)
	);

	pmmtw_accum #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_accum (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.row_take      (take),
		.row_value     (value_s1),
		.row_flags     (flags_s1),
		.sum_flags     (sum_flags),
		.sum_plain_min (sum_plain_min),
		.sum_plain_max (sum_plain_max),
		.sum_trim_min  (sum_trim_min),
		.sum_trim_max  (sum_trim_max)
	);

	pmmtw_out_reg #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_out_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (sum_load),
		.sum_flags     (sum_flags),
		.sum_plain_min (sum_plain_min),
		.sum_plain_max (sum_plain_max),
		.sum_trim_min  (sum_trim_min),
		.sum_trim_max  (sum_trim_max),
		.free          (out_free),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata)
	);

endmodule

// File: hw/rtl/pmmtw_checker.sv
// port-level checks for the pack summary top level, with bind
`timescale 1ns / 1ps

module pmmtw_checker #(
	parameter int unsigned VALUE_WIDTH = pmmtw_pkg::VALUE_WIDTH_DEF,
	localparam int unsigned OUT_WIDTH  = ((4 * VALUE_WIDTH + 5 + 7) / 8) * 8
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [OUT_WIDTH-1:0] m_tdata
);

	localparam int unsigned PLAIN_HAS = 0;
	localparam int unsigned PMIN_LO   = 1;
	localparam int unsigned PMAX_LO   = 1 + VALUE_WIDTH;
	localparam int unsigned TRIM_HAS  = 2 + 2 * VALUE_WIDTH;
	localparam int unsigned TMIN_LO   = 3 + 2 * VALUE_WIDTH;
	localparam int unsigned TMAX_LO   = 3 + 3 * VALUE_WIDTH;

	logic                   plain_has;
	logic                   trim_has;
	logic [VALUE_WIDTH-1:0] pmin;
	logic [VALUE_WIDTH-1:0] pmax;
	logic [VALUE_WIDTH-1:0] tmin;
	logic [VALUE_WIDTH-1:0] tmax;

	assign plain_has = m_tdata[PLAIN_HAS];
	assign trim_has  = m_tdata[TRIM_HAS];
	assign pmin      = m_tdata[PMIN_LO +: VALUE_WIDTH];
	assign pmax      = m_tdata[PMAX_LO +: VALUE_WIDTH];
	assign tmin      = m_tdata[TMIN_LO +: VALUE_WIDTH];
	assign tmax      = m_tdata[TMAX_LO +: VALUE_WIDTH];

	// a stalled summary holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("summary changed while stalled");

	// input backpressure only comes from a stalled summary
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output backpressure");

	// empty pack reports zero extremes and no trim value
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !plain_has |-> pmin == '0 && pmax == '0 && !trim_has)
		else $error("empty pack with nonzero extremes");

	// trim extremes lie inside the plain extremes
	a_trim_nested: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && trim_has |-> plain_has && pmin <= tmin && tmin <= tmax && tmax <= pmax)
		else $error("trim extremes outside plain extremes");

endmodule

bind pack_min_max_with_trim_window_top pmmtw_checker #(
	.VALUE_WIDTH (VALUE_WIDTH)
) u_pmmtw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// File: test/pack_min_max_with_trim_window_top_tb.sv
// testbench for the pack min/max summary with trim window: directed packs, then random traffic
`timescale 1ns / 1ps

module pack_min_max_with_trim_window_top_tb;

	localparam int unsigned VW        = 64;
	localparam int unsigned IN_W      = ((VW + 7) / 8) * 8;
	localparam int unsigned OUT_W     = ((4 * VW + 5 + 7) / 8) * 8;
	localparam int unsigned CYCLE_CAP = 400000;
	// settling time after the last summary, for the input and result registers to empty
	localparam int unsigned SETTLE    = 6;
	localparam logic [VW-1:0] ALL_ONES = '1;

	// expected content of one pack summary
	typedef struct {
		logic          plain_has_value;
		logic [VW-1:0] plain_min;
		logic [VW-1:0] plain_max;
		logic          null_seen;
		logic          trim_has_value;
		logic [VW-1:0] trim_min;
		logic [VW-1:0] trim_max;
		logic          below_seen;
		logic          above_seen;
	} pack_summary_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [IN_W-1:0]      s_tdata;
	logic [pmmtw_pkg::USER_WIDTH-1:0] s_tuser;
	logic                 s_tlast;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [OUT_W-1:0]     m_tdata;
	logic                 cfg_we;
	logic [pmmtw_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
	logic [VW-1:0]        cfg_wdata;

	// window copy and running pack statistics of the predictor
	logic [VW-1:0] win_lo;
	logic [VW-1:0] win_hi;
	logic [VW-1:0] acc_plain_min;
	logic [VW-1:0] acc_plain_max;
	logic          acc_plain_valid;
	logic          acc_null;
	logic [VW-1:0] acc_trim_min;
	logic [VW-1:0] acc_trim_max;
	logic          acc_trim_valid;
	logic          acc_below;
	logic          acc_above;

	pack_summary_t pending_summaries[$];

	int unsigned error_count;
	int unsigned cycle_count;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;

	pack_min_max_with_trim_window_top #(
		.VALUE_WIDTH(VW)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #4 clk = ~clk;

	// run guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_CAP) begin
			$display("[pack_min_max_with_trim_window_top] ERROR");
			$finish;
		end
	end

	// receiver stalls at random
	always @(negedge clk) begin
		if (arst_n) begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic report_mismatch(input string what, input logic [VW-1:0] got,
			input logic [VW-1:0] want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		error_count++;
	endtask

	task automatic clear_pack_stats();
		acc_plain_min   = '0;
		acc_plain_max   = '0;
		acc_plain_valid = 1'b0;
		acc_null        = 1'b0;
		acc_trim_min    = '0;
		acc_trim_max    = '0;
		acc_trim_valid  = 1'b0;
		acc_below       = 1'b0;
		acc_above       = 1'b0;
	endtask

	// fold one accepted row into the pack statistics; queue a summary on the last row
	task automatic account_row(input logic [VW-1:0] value, input logic del, input logic nul,
			input logic last);
		pack_summary_t sum;
		if (!del) begin
			if (nul) begin
				acc_null = 1'b1;
			end else begin
				if (!acc_plain_valid || value < acc_plain_min) acc_plain_min = value;
				if (!acc_plain_valid || value > acc_plain_max) acc_plain_max = value;
				acc_plain_valid = 1'b1;
				if (value >= win_lo && value < win_hi) begin
					if (!acc_trim_valid || value < acc_trim_min) acc_trim_min = value;
					if (!acc_trim_valid || value > acc_trim_max) acc_trim_max = value;
					acc_trim_valid = 1'b1;
				end else if (value < win_lo) begin
					acc_below = 1'b1;
				end else begin
					acc_above = 1'b1;
				end
			end
		end
		if (last) begin
			sum.plain_has_value = acc_plain_valid;
			sum.plain_min       = acc_plain_valid ? acc_plain_min : '0;
			sum.plain_max       = acc_plain_valid ? acc_plain_max : '0;
			sum.null_seen       = acc_null;
			sum.trim_has_value  = acc_trim_valid;
			sum.trim_min        = acc_trim_valid ? acc_trim_min : '0;
			sum.trim_max        = acc_trim_valid ? acc_trim_max : '0;
			sum.below_seen      = acc_below;
			sum.above_seen      = acc_above;
			pending_summaries.push_back(sum);
			clear_pack_stats();
		end
	endtask

	// summary checker: m_tdata fields from bit 0 up
	always @(posedge clk) begin
		pack_summary_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_summaries.size() == 0) begin
				report_mismatch("unexpected summary", m_tdata[VW:1], '0);
			end else begin
				want = pending_summaries.pop_front();
				if (m_tdata[0] !== want.plain_has_value)
					report_mismatch("plain_has_value", VW'(m_tdata[0]),
						VW'(want.plain_has_value));
				if (m_tdata[VW:1] !== want.plain_min)
					report_mismatch("plain_min", m_tdata[VW:1], want.plain_min);
				if (m_tdata[2*VW:VW+1] !== want.plain_max)
					report_mismatch("plain_max", m_tdata[2*VW:VW+1], want.plain_max);
				if (m_tdata[2*VW+1] !== want.null_seen)
					report_mismatch("null_seen", VW'(m_tdata[2*VW+1]), VW'(want.null_seen));
				if (m_tdata[2*VW+2] !== want.trim_has_value)
					report_mismatch("trim_has_value", VW'(m_tdata[2*VW+2]),
						VW'(want.trim_has_value));
				if (m_tdata[3*VW+2:2*VW+3] !== want.trim_min)
					report_mismatch("trim_min", m_tdata[3*VW+2:2*VW+3], want.trim_min);
				if (m_tdata[4*VW+2:3*VW+3] !== want.trim_max)
					report_mismatch("trim_max", m_tdata[4*VW+2:3*VW+3], want.trim_max);
				if (m_tdata[4*VW+3] !== want.below_seen)
					report_mismatch("below_seen", VW'(m_tdata[4*VW+3]), VW'(want.below_seen));
				if (m_tdata[4*VW+4] !== want.above_seen)
					report_mismatch("above_seen", VW'(m_tdata[4*VW+4]), VW'(want.above_seen));
				if (m_tdata[OUT_W-1:4*VW+5] !== '0)
					report_mismatch("padding", VW'(m_tdata[OUT_W-1:4*VW+5]), '0);
			end
		end
	end

	// one row transaction, with a random gap before it
	task automatic send_row(input logic [VW-1:0] value, input logic del, input logic nul,
			input logic last);
		int unsigned gap;
		logic [pmmtw_pkg::USER_WIDTH-1:0] user;
		gap = 0;
		while (gap < 16 && $urandom_range(99) < send_idle_pct) gap++;
		user = '0;
		user[pmmtw_pkg::USER_IS_DELETED] = del;
		user[pmmtw_pkg::USER_IS_NULL]    = nul;
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		s_tuser  <= user;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		account_row(value, del, nul, last);
	endtask

	// drop valid, wait for every summary, then let the pipeline settle
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_summaries.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// register write while the block is idle
	task automatic write_window(input pmmtw_pkg::cfg_reg_t idx, input logic [VW-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		if (idx == pmmtw_pkg::REG_WINDOW_LOW) win_lo = value;
		else win_hi = value;
	endtask

	task automatic set_window(input logic [VW-1:0] lo, input logic [VW-1:0] hi);
		write_window(pmmtw_pkg::REG_WINDOW_LOW, lo);
		write_window(pmmtw_pkg::REG_WINDOW_HIGH, hi);
	endtask

	// flag handling under the reset window [0, all ones)
	task automatic test_row_flags();
		// zero is inside, all ones sits at the exclusive edge
		send_row('0, 1'b0, 1'b0, 1'b0);
		send_row(ALL_ONES, 1'b0, 1'b0, 1'b1);
		// a pack of only a deleted last row: empty summary
		send_row(64'h1234, 1'b1, 1'b0, 1'b1);
		// null, null with delete, then a plain last row
		send_row(64'h99, 1'b0, 1'b1, 1'b0);
		send_row(64'h77, 1'b1, 1'b1, 1'b0);
		send_row(64'h5, 1'b0, 1'b0, 1'b1);
		// null-only pack
		send_row(ALL_ONES, 1'b0, 1'b1, 1'b1);
		// deleted last row still closes the pack
		send_row(64'h7, 1'b0, 1'b0, 1'b0);
		send_row('0, 1'b1, 1'b0, 1'b1);
		drain();
	endtask

	// window edges, reversed and empty windows
	task automatic test_window_edges();
		set_window(64'd100, 64'd200);
		send_row(64'd99, 1'b0, 1'b0, 1'b0);
		send_row(64'd100, 1'b0, 1'b0, 1'b0);
		send_row(64'd199, 1'b0, 1'b0, 1'b0);
		send_row(64'd200, 1'b0, 1'b0, 1'b0);
		send_row(64'd150, 1'b0, 1'b0, 1'b0);
		send_row(ALL_ONES, 1'b0, 1'b0, 1'b1);
		drain();
		set_window(64'd200, 64'd100);
		send_row(64'd150, 1'b0, 1'b0, 1'b0);
		send_row(64'd50, 1'b0, 1'b0, 1'b0);
		send_row(64'd250, 1'b0, 1'b0, 1'b1);
		drain();
		set_window(64'd100, 64'd100);
		send_row(64'd100, 1'b0, 1'b0, 1'b0);
		send_row(64'd99, 1'b0, 1'b0, 1'b1);
		drain();
	endtask

	// value drawn near the window edges, the extremes, or anywhere
	function automatic logic [VW-1:0] pick_value();
		case ($urandom_range(11))
			0: pick_value = '0;
			1: pick_value = ALL_ONES;
			2: pick_value = win_lo;
			3: pick_value = win_lo - 1;
			4: pick_value = win_hi;
			5: pick_value = win_hi - 1;
			6: pick_value = VW'($urandom_range(255));
			7, 8: pick_value = win_lo + VW'($urandom_range(1000));
			default: pick_value = {$urandom, $urandom};
		endcase
	endfunction

	// random packs across several windows for one idling pattern
	task automatic test_random_packs(input int unsigned s_idle, input int unsigned r_idle,
			input int unsigned rows_per_window);
		int unsigned sent;
		int unsigned pack_len;
		logic [VW-1:0] a;
		logic [VW-1:0] b;
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		for (int k = 0; k < 5; k++) begin
			a = {$urandom, $urandom};
			b = {$urandom, $urandom};
			case (k)
				0: set_window('0, ALL_ONES);
				1: set_window((a < b) ? a : b, (a < b) ? b : a);
				2: set_window(ALL_ONES, '0);
				3: set_window(VW'($urandom_range(5000)), VW'($urandom_range(5000)));
				default: set_window(a, a);
			endcase
			sent = 0;
			while (sent < rows_per_window) begin
				pack_len = ($urandom_range(9) == 0) ? $urandom_range(30, 9)
					: $urandom_range(8, 1);
				for (int i = 0; i < pack_len; i++) begin
					send_row(pick_value(), $urandom_range(7) == 0, $urandom_range(7) == 0,
						i == pack_len - 1);
				end
				sent += pack_len;
			end
			drain();
		end
	endtask

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = '0;
		s_tlast       = 1'b0;
		m_tready      = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = pmmtw_pkg::REG_WINDOW_LOW;
		cfg_wdata     = '0;
		error_count   = 0;
		cycle_count   = 0;
		send_idle_pct = 18;
		recv_idle_pct = 46;
		win_lo        = '0;
		win_hi        = ALL_ONES;
		clear_pack_stats();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_row_flags();
		test_window_edges();
		test_random_packs(18, 46, 38);
		test_random_packs(46, 18, 38);
		test_random_packs(0, 0, 38);

		if (pending_summaries.size() != 0)
			report_mismatch("missing summaries", VW'(pending_summaries.size()), '0);
		if (error_count == 0) begin
			$display("[pack_min_max_with_trim_window_top] OK");
		end else begin
			$display("[pack_min_max_with_trim_window_top] ERROR");
		end
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/pmmtw_pkg.sv
hw/rtl/pmmtw_in_stage.sv
hw/rtl/pmmtw_accum.sv
hw/rtl/pmmtw_out_reg.sv
hw/rtl/pack_min_max_with_trim_window_top.sv
hw/rtl/pmmtw_checker.sv
test/pack_min_max_with_trim_window_top_tb.sv
